>>> rtl/cda_pkg.sv
package cda_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned DIV_W  = 34;
  localparam int unsigned DVS_W  = 7;
  localparam int unsigned RCP_W  = 39;
  localparam int unsigned RCP_LO = 20;
  localparam int unsigned RCP_SH = 41;

  localparam logic [YEAR_W-1:0] GAP_YEAR   = 14'd1752;
  localparam logic [YEAR_W-1:0] MAX_YEAR   = 14'd9999;
  localparam logic [YEAR_W-1:0] JUL_RESET  = 14'd1752;

  localparam logic [DVS_W-1:0] DV_SEC  = 7'd60;
  localparam logic [DVS_W-1:0] DV_HOUR = 7'd24;
  localparam logic [DVS_W-1:0] DV_MON  = 7'd12;
  localparam logic [DVS_W-1:0] DV_CENT = 7'd100;
  localparam logic [DVS_W-1:0] DV_WEEK = 7'd7;

  typedef enum logic [2:0] {
    ACT_SEC  = 3'd0,
    ACT_MIN  = 3'd1,
    ACT_HOUR = 3'd2,
    ACT_DAY  = 3'd3,
    ACT_MON  = 3'd4,
    ACT_YEAR = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEC, S_MIN, S_HOUR, S_MON, S_WALK, S_ZST, S_ZY, S_ZM, S_DONE
  } state_t;

  // ceil(2^41 / d): exact floor quotient for magnitudes below 2^34, divisors up to 100
  function automatic logic [RCP_W-1:0] rcp_of(input logic [DVS_W-1:0] d);
    logic [RCP_W-1:0] r;
    unique case (d)
      DV_SEC:  r = 39'd36650387593;
      DV_HOUR: r = 39'd91625968982;
      DV_MON:  r = 39'd183251937963;
      DV_CENT: r = 39'd21990232556;
      DV_WEEK: r = 39'd314146179365;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                   input logic [YEAR_W-1:0] jul);
    logic [26:0] prod;
    logic [7:0] cent;
    logic [YEAR_W-1:0] rem;
    // y / 100 by reciprocal, exact for all 14-bit years
    prod = 27'(y) * 27'd5243;
    cent = prod[26:19];
    rem  = y - 14'({6'b0, cent} * 14'd100);
    return (y[1:0] == 2'b00) &&
           ((y <= jul) || (rem != 14'd0) || (cent[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_days(input logic [YEAR_W-1:0] y,
                                            input logic [3:0] m,
                                            input logic [YEAR_W-1:0] jul);
    logic [4:0] r;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = is_leap(y, jul) ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // (13 * (m + 1)) / 5 for the shifted months 3..14
  function automatic logic [5:0] zel_term(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      4'd13:   r = 6'd36;
      4'd14:   r = 6'd39;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cda_div.sv
module cda_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [cda_pkg::DIV_W-1:0]  dividend,
  input  logic [cda_pkg::DVS_W-1:0]         divisor,
  output logic                              done,
  output logic signed [cda_pkg::DIV_W-1:0]  quo,
  output logic [cda_pkg::DVS_W-1:0]         rem
);

  localparam int unsigned DW = cda_pkg::DIV_W;
  localparam int unsigned VW = cda_pkg::DVS_W;
  localparam int unsigned RW = cda_pkg::RCP_W;
  localparam int unsigned LW = cda_pkg::RCP_LO;
  localparam int unsigned SH = cda_pkg::RCP_SH;
  localparam int unsigned PW = DW + LW;
  localparam int unsigned HW = DW + RW - LW;

  logic            run_r;
  logic            ph_r;
  logic            done_r;
  logic [DW-1:0]   mag_r;
  logic [VW-1:0]   div_r;
  logic [RW-1:0]   rcp_r;
  logic            neg_r;
  logic [PW-1:0]   lo_r;
  logic [DW-1:0]   q_r;
  logic [HW-1:0]   hi_prod;
  logic [PW-1:0]   hi_sum;
  logic [VW-1:0]   qd_lo;
  logic [VW-1:0]   rem_raw;
  logic            fix;

  // magnitude times reciprocal in two halves, then the low bits give the remainder
  assign hi_prod = mag_r * rcp_r[RW-1:LW];
  assign hi_sum  = PW'(hi_prod) + PW'(lo_r[PW-1:LW]);
  assign qd_lo   = q_r[VW-1:0] * div_r;
  assign rem_raw = mag_r[VW-1:0] - qd_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= 1'b0;
        mag_r <= dividend[DW-1] ? -dividend : dividend;
        div_r <= divisor;
        rcp_r <= cda_pkg::rcp_of(divisor);
        neg_r <= dividend[DW-1];
      end else if (run_r) begin
        if (!ph_r) begin
          lo_r <= mag_r * rcp_r[LW-1:0];
          ph_r <= 1'b1;
        end else begin
          q_r    <= DW'(hi_sum[PW-1:SH-LW]);
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // floor correction for negative dividends
  assign fix  = neg_r && (rem_raw != '0);
  assign done = done_r;
  assign quo  = fix   ? $signed(~q_r) :
                neg_r ? -$signed(q_r) : $signed(q_r);
  assign rem  = fix ? div_r - rem_raw : rem_raw;

  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (rem < div_r)) else $error("remainder not below divisor");
  a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !done) else $error("done right after start");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held for more than one cycle");

endmodule

>>> rtl/calendar_datetime_adder.sv
// calendar date-time adder
// input: pulse start with the date-time, unit code (in_action) and signed in_amount
// while busy is low; the beat is taken at that edge and busy stays high until done.
// cfg_valid/cfg_data write the last year of the plain every-fourth-year leap rule;
// cfg_ready is always high, and writes belong between items.
// output: one beat per item, out_strobe high for exactly one cycle with all out_
// fields; the receiver cannot stall, so the beat must be captured then.
// operation: every floor divide and the weekday steps go through one shared divider
// (two-step reciprocal multiply). seconds adds take 3 passes, minutes 2, hours 1,
// months 1, and the weekday 2 more; day carries then walk one month per cycle.
// invalid input goes straight to the result beat.
// a new item is taken only once the last one is through and busy is low.
// reset: sync active-low; clears the sequencer and sets the leap-rule year to 1752.
module calendar_datetime_adder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         in_action,
  input  logic signed [31:0]                 in_amount,
  input  logic [cda_pkg::YEAR_W-1:0]         in_year,
  input  logic [3:0]                         in_month,
  input  logic [4:0]                         in_day,
  input  logic [4:0]                         in_hour,
  input  logic [5:0]                         in_minute,
  input  logic [5:0]                         in_second,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cda_pkg::YEAR_W-1:0]         cfg_data,
  output logic                               out_strobe,
  output logic [cda_pkg::YEAR_W-1:0]         out_year,
  output logic [3:0]                         out_month,
  output logic [4:0]                         out_day,
  output logic [4:0]                         out_hour,
  output logic [5:0]                         out_minute,
  output logic [5:0]                         out_second,
  output logic [2:0]                         out_weekday,
  output logic                               out_input_valid,
  output logic                               out_of_range
);

  localparam int unsigned YW = cda_pkg::YEAR_W;
  localparam int unsigned DW = cda_pkg::DIV_W;

  cda_pkg::state_t state_r, state_nxt;

  logic [YW-1:0] jul_r;
  logic [YW-1:0] ey_r, ey_nxt;
  logic [3:0]    em_r, em_nxt;
  logic [4:0]    ed_r, ed_nxt, eh_r, eh_nxt;
  logic [5:0]    emi_r, emi_nxt, es_r, es_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [3:0]    m_r, m_nxt, zm_r, zm_nxt;
  logic [4:0]    d_r, d_nxt, h_r, h_nxt;
  logic [5:0]    mi_r, mi_nxt, s_r, s_nxt;
  logic signed [DW-1:0] n_r, n_nxt;
  logic [2:0]    wd_r, wd_nxt;
  logic          valid_r, valid_nxt, fail_r, fail_nxt;
  logic          strobe_r, strobe_nxt;
  logic [YW-1:0] oy_r, oy_nxt;
  logic [3:0]    om_r, om_nxt;
  logic [4:0]    od_r, od_nxt, oh_r, oh_nxt;
  logic [5:0]    omi_r, omi_nxt, os_r, os_nxt;
  logic [2:0]    ow_r, ow_nxt;
  logic          ov_r, ov_nxt, oo_r, oo_nxt;

  logic                        div_start;
  logic signed [DW-1:0]        div_a;
  logic [cda_pkg::DVS_W-1:0]   div_d;
  logic                        div_done;
  logic signed [DW-1:0]        div_q;
  logic [cda_pkg::DVS_W-1:0]   div_rem;

  logic                 accept;
  logic                 in_ok;
  logic signed [DW-1:0] amt_x, yr_sum, mon_t;
  logic                 yr_ok, q_ok;
  logic [4:0]           md_cur, left, md_dec;
  logic [3:0]           m_dec;
  logic [YW-1:0]        y_dec, zy;
  logic                 fwd_fit, bk_fit, fail_fwd, fail_bk, zadj;
  logic [6:0]           zk, zj;
  logic [9:0]           zsum;

  cda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  assign accept    = start && !busy;
  assign busy      = (state_r != cda_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // input checks
  assign in_ok = (in_year >= 14'd1) && (in_year <= cda_pkg::MAX_YEAR) &&
                 (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day >= 5'd1) &&
                 !((in_year == cda_pkg::GAP_YEAR) && (in_month == 4'd9) &&
                   (in_day > 5'd2) && (in_day < 5'd14)) &&
                 (in_day <= cda_pkg::month_days(in_year, in_month, jul_r)) &&
                 (in_hour < 5'd24) && (in_minute < 6'd60) && (in_second < 6'd60);

  assign amt_x  = {{(DW-32){in_amount[31]}}, in_amount};
  assign yr_sum = $signed({{(DW-YW){1'b0}}, in_year}) + amt_x;
  assign yr_ok  = (yr_sum >= 34'sd1) && (yr_sum <= 34'sd9999);
  assign mon_t  = $signed({{(DW-YW-3){1'b0}}, in_year, 3'b0}) +
                  $signed({{(DW-YW-2){1'b0}}, in_year, 2'b0}) +
                  $signed({{(DW-4){1'b0}}, in_month}) - 34'sd1 + amt_x;
  assign q_ok   = (div_q >= 34'sd1) && (div_q <= 34'sd9999);

  // month walk
  assign md_cur   = cda_pkg::month_days(y_r, m_r, jul_r);
  assign left     = md_cur - d_r;
  assign fwd_fit  = n_r <= $signed({{(DW-5){1'b0}}, left});
  assign bk_fit   = ($signed({{(DW-5){1'b0}}, d_r}) + n_r) > 34'sd0;
  assign m_dec    = (m_r == 4'd1) ? 4'd12 : m_r - 4'd1;
  assign y_dec    = (m_r == 4'd1) ? y_r - 14'd1 : y_r;
  assign md_dec   = cda_pkg::month_days(y_dec, m_dec, jul_r);
  assign fail_fwd = (m_r == 4'd12) && (y_r == cda_pkg::MAX_YEAR);
  assign fail_bk  = (m_r == 4'd1) && (y_r == 14'd1);

  // weekday terms
  assign zadj = m_r < 4'd3;
  assign zy   = zadj ? y_r - 14'd1 : y_r;
  assign zk   = div_rem;
  assign zj   = div_q[6:0];
  assign zsum = 10'(d_r) + 10'(cda_pkg::zel_term(zm_r)) + 10'(zk) + 10'(zk[6:2]) +
                10'(zj[6:2]) + {1'b0, zj, 2'b0} + {3'b0, zj};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        if (accept) begin
          if (!in_ok) begin
            state_nxt = cda_pkg::S_DONE;
          end else begin
            case (in_action)
              cda_pkg::ACT_SEC:  state_nxt = cda_pkg::S_SEC;
              cda_pkg::ACT_MIN:  state_nxt = cda_pkg::S_MIN;
              cda_pkg::ACT_HOUR: state_nxt = cda_pkg::S_HOUR;
              cda_pkg::ACT_DAY:  state_nxt = cda_pkg::S_WALK;
              cda_pkg::ACT_MON:  state_nxt = cda_pkg::S_MON;
              cda_pkg::ACT_YEAR: state_nxt = yr_ok ? cda_pkg::S_ZST : cda_pkg::S_DONE;
              default:           state_nxt = cda_pkg::S_ZST;
            endcase
          end
        end
      end
      cda_pkg::S_SEC:  if (div_done) state_nxt = cda_pkg::S_MIN;
      cda_pkg::S_MIN:  if (div_done) state_nxt = cda_pkg::S_HOUR;
      cda_pkg::S_HOUR: if (div_done) state_nxt = cda_pkg::S_WALK;
      cda_pkg::S_MON:  if (div_done) state_nxt = q_ok ? cda_pkg::S_ZST : cda_pkg::S_DONE;
      cda_pkg::S_WALK: begin
        if (n_r == 34'sd0)
          state_nxt = cda_pkg::S_ZST;
        else if (n_r > 34'sd0 && !fwd_fit && fail_fwd)
          state_nxt = cda_pkg::S_DONE;
        else if (n_r < 34'sd0 && !bk_fit && fail_bk)
          state_nxt = cda_pkg::S_DONE;
      end
      cda_pkg::S_ZST:  state_nxt = cda_pkg::S_ZY;
      cda_pkg::S_ZY:   if (div_done) state_nxt = cda_pkg::S_ZM;
      cda_pkg::S_ZM:   if (div_done) state_nxt = cda_pkg::S_DONE;
      cda_pkg::S_DONE: state_nxt = cda_pkg::S_IDLE;
      default:         state_nxt = cda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ey_nxt = ey_r; em_nxt = em_r; ed_nxt = ed_r;
    eh_nxt = eh_r; emi_nxt = emi_r; es_nxt = es_r;
    y_nxt = y_r; m_nxt = m_r; d_nxt = d_r; h_nxt = h_r; mi_nxt = mi_r; s_nxt = s_r;
    n_nxt = n_r; zm_nxt = zm_r; wd_nxt = wd_r;
    valid_nxt = valid_r; fail_nxt = fail_r;
    oy_nxt = oy_r; om_nxt = om_r; od_nxt = od_r; oh_nxt = oh_r;
    omi_nxt = omi_r; os_nxt = os_r; ow_nxt = ow_r; ov_nxt = ov_r; oo_nxt = oo_r;
    strobe_nxt = 1'b0;
    div_start = 1'b0;
    div_a     = '0;
    div_d     = cda_pkg::DV_SEC;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        if (accept) begin
          ey_nxt = in_year; em_nxt = in_month; ed_nxt = in_day;
          eh_nxt = in_hour; emi_nxt = in_minute; es_nxt = in_second;
          y_nxt = in_year; m_nxt = in_month; d_nxt = in_day;
          h_nxt = in_hour; mi_nxt = in_minute; s_nxt = in_second;
          n_nxt = amt_x;
          valid_nxt = in_ok;
          fail_nxt  = 1'b0;
          if (in_ok) begin
            case (in_action)
              cda_pkg::ACT_SEC: begin
                div_start = 1'b1;
                div_a = $signed({{(DW-6){1'b0}}, in_second}) + amt_x;
                div_d = cda_pkg::DV_SEC;
              end
              cda_pkg::ACT_MIN: begin
                div_start = 1'b1;
                div_a = $signed({{(DW-6){1'b0}}, in_minute}) + amt_x;
                div_d = cda_pkg::DV_SEC;
              end
              cda_pkg::ACT_HOUR: begin
                div_start = 1'b1;
                div_a = $signed({{(DW-5){1'b0}}, in_hour}) + amt_x;
                div_d = cda_pkg::DV_HOUR;
              end
              cda_pkg::ACT_MON: begin
                div_start = 1'b1;
                div_a = mon_t;
                div_d = cda_pkg::DV_MON;
              end
              cda_pkg::ACT_YEAR: begin
                y_nxt    = yr_sum[YW-1:0];
                fail_nxt = !yr_ok;
              end
              default: ;
            endcase
          end
        end
      end
      cda_pkg::S_SEC: begin
        if (div_done) begin
          s_nxt     = div_rem[5:0];
          div_start = 1'b1;
          div_a     = $signed({{(DW-6){1'b0}}, mi_r}) + div_q;
          div_d     = cda_pkg::DV_SEC;
        end
      end
      cda_pkg::S_MIN: begin
        if (div_done) begin
          mi_nxt    = div_rem[5:0];
          div_start = 1'b1;
          div_a     = $signed({{(DW-5){1'b0}}, h_r}) + div_q;
          div_d     = cda_pkg::DV_HOUR;
        end
      end
      cda_pkg::S_HOUR: begin
        if (div_done) begin
          h_nxt = div_rem[4:0];
          n_nxt = div_q;
        end
      end
      cda_pkg::S_MON: begin
        if (div_done) begin
          if (q_ok) begin
            y_nxt = div_q[YW-1:0];
            m_nxt = div_rem[3:0] + 4'd1;
          end else begin
            fail_nxt = 1'b1;
          end
        end
      end
      cda_pkg::S_WALK: begin
        if (n_r > 34'sd0) begin
          if (fwd_fit) begin
            d_nxt = d_r + n_r[4:0];
            n_nxt = '0;
          end else if (fail_fwd) begin
            fail_nxt = 1'b1;
          end else begin
            n_nxt = n_r - $signed({{(DW-6){1'b0}}, 6'(left) + 6'd1});
            d_nxt = 5'd1;
            if (m_r == 4'd12) begin
              m_nxt = 4'd1;
              y_nxt = y_r + 14'd1;
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end
        end else if (n_r < 34'sd0) begin
          if (bk_fit) begin
            d_nxt = d_r + n_r[4:0];
            n_nxt = '0;
          end else if (fail_bk) begin
            fail_nxt = 1'b1;
          end else begin
            n_nxt = n_r + $signed({{(DW-5){1'b0}}, d_r});
            m_nxt = m_dec;
            y_nxt = y_dec;
            d_nxt = md_dec;
          end
        end
      end
      cda_pkg::S_ZST: begin
        // january and february count as months 13 and 14 of the prior year
        zm_nxt    = zadj ? m_r + 4'd12 : m_r;
        div_start = 1'b1;
        div_a     = $signed({{(DW-YW){1'b0}}, zy});
        div_d     = cda_pkg::DV_CENT;
      end
      cda_pkg::S_ZY: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = $signed({{(DW-10){1'b0}}, zsum});
          div_d     = cda_pkg::DV_WEEK;
        end
      end
      cda_pkg::S_ZM: begin
        if (div_done)
          wd_nxt = (div_rem == 7'd0) ? 3'd6 : 3'(div_rem - 7'd1);
      end
      cda_pkg::S_DONE: begin
        strobe_nxt = 1'b1;
        ov_nxt     = valid_r;
        oo_nxt     = valid_r && fail_r;
        if (!valid_r || fail_r) begin
          oy_nxt = ey_r; om_nxt = em_r; od_nxt = ed_r;
          oh_nxt = eh_r; omi_nxt = emi_r; os_nxt = es_r;
          ow_nxt = 3'd0;
        end else begin
          oy_nxt = y_r; om_nxt = m_r; od_nxt = d_r;
          oh_nxt = h_r; omi_nxt = mi_r; os_nxt = s_r;
          ow_nxt = wd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cda_pkg::S_IDLE;
      strobe_r <= 1'b0;
      jul_r    <= cda_pkg::JUL_RESET;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready)
        jul_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    ey_r <= ey_nxt; em_r <= em_nxt; ed_r <= ed_nxt;
    eh_r <= eh_nxt; emi_r <= emi_nxt; es_r <= es_nxt;
    y_r <= y_nxt; m_r <= m_nxt; d_r <= d_nxt; h_r <= h_nxt; mi_r <= mi_nxt; s_r <= s_nxt;
    n_r <= n_nxt; zm_r <= zm_nxt; wd_r <= wd_nxt;
    valid_r <= valid_nxt; fail_r <= fail_nxt;
    oy_r <= oy_nxt; om_r <= om_nxt; od_r <= od_nxt; oh_r <= oh_nxt;
    omi_r <= omi_nxt; os_r <= os_nxt; ow_r <= ow_nxt; ov_r <= ov_nxt; oo_r <= oo_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_year        = oy_r;
  assign out_month       = om_r;
  assign out_day         = od_r;
  assign out_hour        = oh_r;
  assign out_minute      = omi_r;
  assign out_second      = os_r;
  assign out_weekday     = ow_r;
  assign out_input_valid = ov_r;
  assign out_of_range    = oo_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result beat while busy");
  a_range_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_of_range) |-> out_input_valid)
    else $error("out of range flagged on invalid input");
  a_invalid_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_input_valid) |-> (out_weekday == 3'd0))
    else $error("weekday set on invalid input");
  a_good_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_input_valid && !out_of_range) |->
      (out_month >= 4'd1 && out_month <= 4'd12 && out_weekday <= 3'd6))
    else $error("result month or weekday out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

endmodule

>>> sim/tb_calendar_datetime_adder.sv
module tb_calendar_datetime_adder;

  localparam int IDLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [2:0]        act;
    logic signed [31:0] amt;
    logic [13:0]       y;
    logic [3:0]        mo;
    logic [4:0]        d;
    logic [4:0]        h;
    logic [5:0]        mi;
    logic [5:0]        s;
  } dt_item_t;

  typedef struct {
    logic [13:0] y;
    logic [3:0]  mo;
    logic [4:0]  d;
    logic [4:0]  h;
    logic [5:0]  mi;
    logic [5:0]  s;
    logic [2:0]  wd;
    logic        iv;
    logic        oor;
  } dt_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_action = '0;
  logic signed [31:0] in_amount = '0;
  logic [13:0] in_year = '0;
  logic [3:0] in_month = '0;
  logic [4:0] in_day = '0;
  logic [4:0] in_hour = '0;
  logic [5:0] in_minute = '0;
  logic [5:0] in_second = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [13:0] cfg_data = '0;
  logic out_strobe;
  logic [13:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [2:0] out_weekday;
  logic out_input_valid;
  logic out_of_range;

  calendar_datetime_adder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_amount(in_amount), .in_year(in_year),
    .in_month(in_month), .in_day(in_day), .in_hour(in_hour),
    .in_minute(in_minute), .in_second(in_second),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_year(out_year), .out_month(out_month),
    .out_day(out_day), .out_hour(out_hour), .out_minute(out_minute),
    .out_second(out_second), .out_weekday(out_weekday),
    .out_input_valid(out_input_valid), .out_of_range(out_of_range)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dt_item_t pending_q[$];
  dt_sum_t  sum_q[$];
  longint   julian_year = cda_pkg::JUL_RESET;
  int       idle_pct = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       huge_left = 5;
  dt_item_t cur;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic bit is_leap_yr(longint y, longint jul);
    if (y % 4 != 0) return 1'b0;
    return (y <= jul) || (y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic longint days_in(longint y, longint m, longint jul);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return is_leap_yr(y, jul) ? 29 : 28;
    return 31;
  endfunction

  function automatic bit date_valid(longint y, longint m, longint d, longint jul);
    if (y < 1 || y > cda_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
    // the eleven days dropped at the calendar switch
    if (y == cda_pkg::GAP_YEAR && m == 9 && d > 2 && d < 14) return 1'b0;
    return d <= days_in(y, m, jul);
  endfunction

  function automatic logic [2:0] zeller_wd(longint y, longint m, longint d);
    longint k, j, hh;
    if (m < 3) begin
      m += 12;
      y--;
    end
    k = y % 100;
    j = y / 100;
    hh = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return 3'((hh + 6) % 7);
  endfunction

  function automatic dt_sum_t add_datetime(dt_item_t it, longint jul);
    longint y, mo, d, h, mi, s, t, c, amt, left;
    bit valid, ok;
    dt_sum_t r;
    amt = it.amt;
    y = it.y; mo = it.mo; d = it.d; h = it.h; mi = it.mi; s = it.s;
    c = 0;
    ok = 1'b1;
    valid = date_valid(y, mo, d, jul) && h < 24 && mi < 60 && s < 60;
    if (valid) begin
      case (it.act)
        cda_pkg::ACT_SEC: begin
          t = s + amt; c = fdiv(t, 60); s = t - c * 60;
          t = mi + c; c = fdiv(t, 60); mi = t - c * 60;
          t = h + c; c = fdiv(t, 24); h = t - c * 24;
        end
        cda_pkg::ACT_MIN: begin
          t = mi + amt; c = fdiv(t, 60); mi = t - c * 60;
          t = h + c; c = fdiv(t, 24); h = t - c * 24;
        end
        cda_pkg::ACT_HOUR: begin
          t = h + amt; c = fdiv(t, 24); h = t - c * 24;
        end
        cda_pkg::ACT_DAY: c = amt;
        cda_pkg::ACT_MON: begin
          t = y * 12 + (mo - 1) + amt;
          y = fdiv(t, 12);
          mo = t - y * 12 + 1;
          ok = y >= 1 && y <= cda_pkg::MAX_YEAR;
        end
        cda_pkg::ACT_YEAR: begin
          y += amt;
          ok = y >= 1 && y <= cda_pkg::MAX_YEAR;
        end
        default: ;
      endcase
      if (!ok) c = 0;
      while (c > 0) begin
        left = days_in(y, mo, jul) - d;
        if (c <= left) begin
          d += c;
          c = 0;
        end else begin
          c -= left + 1;
          d = 1;
          mo++;
          if (mo > 12) begin
            mo = 1;
            y++;
            if (y > cda_pkg::MAX_YEAR) begin
              ok = 1'b0;
              c = 0;
            end
          end
        end
      end
      while (c < 0) begin
        if (d + c > 0) begin
          d += c;
          c = 0;
        end else begin
          c += d;
          mo--;
          if (mo < 1) begin
            mo = 12;
            y--;
            if (y < 1) begin
              ok = 1'b0;
              c = 0;
            end
          end
          if (ok) d = days_in(y, mo, jul);
        end
      end
    end
    if (!valid || !ok) begin
      r.y = it.y; r.mo = it.mo; r.d = it.d; r.h = it.h; r.mi = it.mi; r.s = it.s;
      r.wd = '0;
    end else begin
      r.y = 14'(y); r.mo = 4'(mo); r.d = 5'(d); r.h = 5'(h); r.mi = 6'(mi); r.s = 6'(s);
      r.wd = zeller_wd(y, mo, d);
    end
    r.iv = valid;
    r.oor = valid && !ok;
    return r;
  endfunction

  function automatic dt_item_t mk(logic [2:0] act, logic signed [31:0] amt, int y, int mo,
                                  int d, int h, int mi, int s);
    dt_item_t it;
    it.act = act; it.amt = amt; it.y = 14'(y); it.mo = 4'(mo); it.d = 5'(d);
    it.h = 5'(h); it.mi = 6'(mi); it.s = 6'(s);
    return it;
  endfunction

  task automatic gen_random(int n);
    dt_item_t it;
    int yr, dim, sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // raw noise on every field, with a bounded amount for minute, hour and day adds
        it.act = 3'($urandom); it.y = 14'($urandom); it.mo = 4'($urandom);
        it.d = 5'($urandom); it.h = 5'($urandom); it.mi = 6'($urandom);
        it.s = 6'($urandom);
        if (it.act inside {cda_pkg::ACT_MIN, cda_pkg::ACT_HOUR, cda_pkg::ACT_DAY})
          it.amt = $signed(32'($urandom_range(0, 2000))) - 1000;
        else
          it.amt = $urandom;
      end else begin
        case ($urandom_range(0, 5))
          0: yr = $urandom_range(1, 9999);
          1: yr = $urandom_range(1740, 1770);
          2: yr = $urandom_range(1, 40);
          3: yr = $urandom_range(9960, 9999);
          4: yr = $urandom_range(1890, 2110);
          default: yr = $urandom_range(1, 99) * 100;
        endcase
        it.y = 14'(yr);
        it.mo = 4'($urandom_range(1, 12));
        dim = int'(days_in(yr, it.mo, julian_year));
        it.d = ($urandom_range(0, 3) == 0) ? 5'(dim) : 5'($urandom_range(1, dim));
        it.h = 5'($urandom_range(0, 23));
        it.mi = 6'($urandom_range(0, 59));
        it.s = 6'($urandom_range(0, 59));
        it.act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        case ($urandom_range(0, 3))
          0: it.amt = $signed(32'($urandom_range(0, 200))) - 100;
          1: it.amt = $signed(32'($urandom_range(0, 200000))) - 100000;
          default: it.amt = $urandom;
        endcase
        // full-range day carries walk for a long time, keep them rare
        if (it.act inside {cda_pkg::ACT_MIN, cda_pkg::ACT_HOUR, cda_pkg::ACT_DAY} &&
            (it.amt > 200000 || it.amt < -200000)) begin
          if (huge_left > 0 && $urandom_range(0, 49) == 0) huge_left--;
          else it.amt = $signed(32'($urandom_range(0, 40000))) - 20000;
        end
      end
      pending_q.push_back(it);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || start || sum_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_julian(logic [13:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    julian_year = v;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        sum_q.push_back(add_datetime(cur, julian_year));
      if (!start || !busy) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur = pending_q.pop_front();
          in_action <= cur.act; in_amount <= cur.amt; in_year <= cur.y;
          in_month <= cur.mo; in_day <= cur.d; in_hour <= cur.h;
          in_minute <= cur.mi; in_second <= cur.s;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    dt_sum_t e;
    if (rst_n && out_strobe) begin
      if (sum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %0d-%0d-%0d", out_year,
                                       out_month, out_day);
      end else begin
        e = sum_q.pop_front();
        if (e.y !== out_year || e.mo !== out_month || e.d !== out_day ||
            e.h !== out_hour || e.mi !== out_minute || e.s !== out_second ||
            e.wd !== out_weekday || e.iv !== out_input_valid || e.oor !== out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d-%0d-%0d %0d:%0d:%0d wd%0d v%0d r%0d got %0d-%0d-%0d %0d:%0d:%0d wd%0d v%0d r%0d",
                     e.y, e.mo, e.d, e.h, e.mi, e.s, e.wd, e.iv, e.oor,
                     out_year, out_month, out_day, out_hour, out_minute, out_second,
                     out_weekday, out_input_valid, out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [13:0] jul_set [7];
    int idle_mode [4];
    jul_set = '{14'd1752, 14'd0, 14'd9999, 14'd1582, 14'd1752, 14'd0, 14'd0};
    idle_mode = '{0, 58, 0, 33};
    jul_set[5] = 14'($urandom_range(0, 9999));
    jul_set[6] = 14'($urandom_range(1, 9999));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: range edges, calendar switch, leap rules, every unit
    pending_q.push_back(mk(cda_pkg::ACT_SEC, -1, 1, 1, 1, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 1, 9999, 12, 31, 23, 59, 59));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 32'sh8000_0000, 2000, 6, 15, 12, 30, 30));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 32'sh7fff_ffff, 2000, 6, 15, 12, 30, 30));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, 1, 1752, 9, 2, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, 0, 1752, 9, 3, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, 0, 1752, 9, 13, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, -1, 1752, 9, 14, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, 1, 1700, 2, 29, 1, 2, 3));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, 1, 1900, 2, 29, 1, 2, 3));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, 1, 2000, 2, 29, 1, 2, 3));
    pending_q.push_back(mk(cda_pkg::ACT_DAY, -1, 1, 3, 1, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_MON, 1, 2023, 1, 31, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_MON, 32'sh7fff_ffff, 2023, 1, 31, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_MON, -13, 2023, 1, 31, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_YEAR, 1, 2000, 2, 29, 5, 6, 7));
    pending_q.push_back(mk(cda_pkg::ACT_YEAR, -2000, 2000, 2, 29, 5, 6, 7));
    pending_q.push_back(mk(cda_pkg::ACT_MIN, -61, 2024, 3, 1, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_HOUR, 25, 2024, 2, 28, 23, 59, 59));
    pending_q.push_back(mk(3'd6, 100, 2024, 5, 5, 5, 5, 5));
    pending_q.push_back(mk(3'd7, -100, 2024, 5, 5, 5, 5, 5));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 5, 0, 0, 0, 24, 60, 60));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 5, 16383, 15, 31, 31, 63, 63));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 5, 2024, 13, 0, 0, 0, 0));
    pending_q.push_back(mk(cda_pkg::ACT_SEC, 5, 2024, 4, 31, 0, 0, 0));
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p != 0) write_julian(jul_set[p]);
      idle_pct = idle_mode[p % 4];
      gen_random(220);
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && sum_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cda_pkg.sv
rtl/cda_div.sv
rtl/calendar_datetime_adder.sv
sim/tb_calendar_datetime_adder.sv
